// File: design/akpt_pkg.sv
// shared types and constants of the accelerometer kalman position tracker
package akpt_pkg;

  localparam int unsigned CALIB_SAMPLES = 400;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned DIV_NUM_W     = 64;
  localparam int unsigned DIV_DEN_W     = 34;
  localparam int unsigned DIV_CNT_W     = 7;

  localparam logic [31:0] ONE_Q24      = 32'd16777216;
  localparam logic [31:0] Q_RESET      = 32'd167772;
  localparam logic [31:0] R_RESET      = 32'd105;
  localparam logic [17:0] CONV_NUM     = 18'd251136;
  localparam logic [33:0] CONV_DEN     = 34'd25;
  localparam logic [33:0] CAL_DEN      = 34'(25 * CALIB_SAMPLES);
  localparam logic [33:0] POS_DEN      = 34'd625;

  typedef enum logic [0:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic               read_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] smooth_x;
    logic signed [31:0] smooth_y;
    logic signed [31:0] smooth_z;
    logic signed [63:0] position_x;
    logic signed [63:0] position_y;
    logic signed [63:0] position_z;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: design/akpt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module akpt_div import akpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_NUM_W-1:0] acc_q, acc_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 qbit;

  always_comb begin
    rem_sh = {rem_q, acc_q[DIV_NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (req_i.start) begin
      acc_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = DIV_CNT_W'(DIV_NUM_W);
      done_d = 1'b0;
    end else if (cnt_q != '0) begin
      rem_d = qbit ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : DIV_DEN_W'(rem_sh);
      acc_d = {acc_q[DIV_NUM_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

// File: design/accel_kalman_position_tracker_unit.sv
// accelerometer calibration, per-axis scalar kalman filter and position accumulator
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------
//  in       | input     | in_valid_i / in_ready_o  | in_item_i  (in_item_t)
//  out      | output    | out_valid_o / out_ready_i| out_item_o (out_item_t)
//  cfg      | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// each divide has a start state and a wait state until the quotient is ready
// a calibration item is taken in idle; the last one then computes the three offsets
// a good item holds the input through all three axes and until the output is free;
// no gain divide if covariance and both noise values are zero; a failed item is dropped
// reset sets covariance to one, clears the other filter state and loads noise defaults
// the output register holds a finished item, so the next item is taken while it waits
module accel_kalman_position_tracker_unit import akpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_CAL_START  = 13'b0000000000010,
    S_CAL_DIV    = 13'b0000000000100,
    S_CONV_START = 13'b0000000001000,
    S_CONV_DIV   = 13'b0000000010000,
    S_K_START    = 13'b0000000100000,
    S_K_DIV      = 13'b0000001000000,
    S_MUL_E      = 13'b0000010000000,
    S_UPD_X      = 13'b0000100000000,
    S_UPD_P      = 13'b0001000000000,
    S_POS_DIV    = 13'b0010000000000,
    S_POS_ADD    = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]        q_noise_q, r_noise_q;
  logic [CNT_W-1:0]   calib_cnt_q, calib_cnt_d;
  logic signed [24:0] raw_sum_q [3];
  logic signed [31:0] offset_q  [3];
  logic signed [31:0] est_q     [3];
  logic [31:0]        cov_q     [3];
  logic signed [63:0] pos_q     [3];
  logic signed [15:0] raw_q     [3];
  logic [1:0]         axis_q, axis_d;
  logic               neg_q, neg_d;
  logic signed [33:0] meas_q, meas_d;
  logic [31:0]        p_q, p_d;
  logic [24:0]        k_q, k_d;
  logic signed [60:0] prod_q, prod_d;
  logic [56:0]        cprod_q, cprod_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  akpt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic               accept;
  logic [CNT_W-1:0]   cnt_inc;
  logic signed [24:0] sum_cur;
  logic [24:0]        sum_mag;
  logic signed [15:0] raw_cur;
  logic [15:0]        raw_mag;
  logic signed [34:0] qsigned;
  logic [32:0]        p_wide;
  logic [31:0]        p_sat;
  logic [32:0]        s_sum;
  logic signed [34:0] err;
  logic [60:0]        prod_mag;
  logic [36:0]        dmag;
  logic signed [39:0] x_new;
  logic signed [31:0] x_sat;
  logic [31:0]        f_mag;
  logic signed [64:0] pos_sum;
  logic signed [63:0] pos_sat;
  logic               out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_inc    = calib_cnt_q + 1'b1;

  always_comb begin
    sum_cur  = raw_sum_q[axis_q];
    sum_mag  = sum_cur[24] ? 25'(-sum_cur) : 25'(sum_cur);
    raw_cur  = raw_q[axis_q];
    raw_mag  = raw_cur[15] ? 16'(-raw_cur) : 16'(raw_cur);
    qsigned  = neg_q ? -$signed({1'b0, div_rsp.quot[33:0]})
                     : $signed({1'b0, div_rsp.quot[33:0]});
    p_wide   = {1'b0, cov_q[axis_q]} + {1'b0, q_noise_q};
    p_sat    = p_wide[32] ? 32'hFFFF_FFFF : p_wide[31:0];
    s_sum    = {1'b0, p_sat} + {1'b0, r_noise_q};
    err      = 35'(meas_q) - 35'(est_q[axis_q]);
    prod_mag = prod_q[60] ? 61'(-prod_q) : 61'(prod_q);
    dmag     = 37'((prod_mag + 61'd8388608) >> 24);
    x_new    = prod_q[60] ? 40'(est_q[axis_q]) - $signed({3'b0, dmag})
                          : 40'(est_q[axis_q]) + $signed({3'b0, dmag});
    if (x_new > 40'sd2147483647) begin
      x_sat = 32'sh7FFF_FFFF;
    end else if (x_new < -40'sd2147483648) begin
      x_sat = 32'sh8000_0000;
    end else begin
      x_sat = 32'(x_new);
    end
    f_mag    = est_q[axis_q][31] ? 32'(-est_q[axis_q]) : 32'(est_q[axis_q]);
    pos_sum  = 65'(pos_q[axis_q]) + 65'(qsigned);
    if (pos_sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      pos_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (pos_sum < -65'sh0_8000_0000_0000_0000) begin
      pos_sat = 64'sh8000_0000_0000_0000;
    end else begin
      pos_sat = 64'(pos_sum);
    end
  end

  always_comb begin
    state_d     = state_q;
    calib_cnt_d = calib_cnt_q;
    axis_d      = axis_q;
    neg_d       = neg_q;
    meas_d      = meas_q;
    p_d         = p_q;
    k_d         = k_q;
    prod_d      = prod_q;
    cprod_d     = cprod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_req     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          axis_d = 2'd0;
          if (calib_cnt_q < CNT_W'(CALIB_SAMPLES)) begin
            calib_cnt_d = cnt_inc;
            if (cnt_inc == CNT_W'(CALIB_SAMPLES)) begin
              state_d = S_CAL_START;
            end
          end else if (in_item_i.read_ok) begin
            state_d = S_CONV_START;
          end
        end
      end
      S_CAL_START: begin
        neg_d         = sum_cur[24];
        div_req.start = 1'b1;
        div_req.num   = 64'(sum_mag) * 64'(CONV_NUM) + 64'(CAL_DEN >> 1);
        div_req.den   = CAL_DEN;
        state_d       = S_CAL_DIV;
      end
      S_CAL_DIV: begin
        if (div_rsp.done) begin
          if (axis_q == 2'd2) begin
            state_d = S_IDLE;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_CAL_START;
          end
        end
      end
      S_CONV_START: begin
        neg_d         = raw_cur[15];
        div_req.start = 1'b1;
        div_req.num   = 64'(raw_mag) * 64'(CONV_NUM) + 64'(CONV_DEN >> 1);
        div_req.den   = CONV_DEN;
        state_d       = S_CONV_DIV;
      end
      S_CONV_DIV: begin
        if (div_rsp.done) begin
          meas_d  = 34'(qsigned) - 34'(offset_q[axis_q]);
          state_d = S_K_START;
        end
      end
      S_K_START: begin
        p_d = p_sat;
        if (s_sum == '0) begin
          k_d     = 25'(ONE_Q24);
          state_d = S_MUL_E;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {8'd0, p_sat, 24'd0} + 64'(s_sum >> 1);
          div_req.den   = 34'(s_sum);
          state_d       = S_K_DIV;
        end
      end
      S_K_DIV: begin
        if (div_rsp.done) begin
          k_d     = div_rsp.quot[24:0];
          state_d = S_MUL_E;
        end
      end
      S_MUL_E: begin
        prod_d  = 61'($signed({1'b0, k_q}) * err);
        state_d = S_UPD_X;
      end
      S_UPD_X: begin
        cprod_d = 57'(p_q) * 57'(25'(ONE_Q24) - k_q);
        state_d = S_UPD_P;
      end
      S_UPD_P: begin
        neg_d         = est_q[axis_q][31];
        div_req.start = 1'b1;
        div_req.num   = {20'd0, f_mag, 12'd0} + 64'(POS_DEN >> 1);
        div_req.den   = POS_DEN;
        state_d       = S_POS_DIV;
      end
      S_POS_DIV: begin
        if (div_rsp.done) begin
          state_d = S_POS_ADD;
        end
      end
      S_POS_ADD: begin
        if (axis_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_CONV_START;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      q_noise_q   <= Q_RESET;
      r_noise_q   <= R_RESET;
      calib_cnt_q <= '0;
      out_valid_q <= 1'b0;
      axis_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        raw_sum_q[i] <= '0;
        offset_q[i]  <= '0;
        est_q[i]     <= '0;
        cov_q[i]     <= ONE_Q24;
        pos_q[i]     <= '0;
      end
    end else begin
      state_q     <= state_d;
      calib_cnt_q <= calib_cnt_d;
      out_valid_q <= out_valid_d;
      axis_q      <= axis_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROCESS_NOISE:     q_noise_q <= cfg_data_i;
          REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && (calib_cnt_q < CNT_W'(CALIB_SAMPLES)) && in_item_i.read_ok) begin
        raw_sum_q[0] <= raw_sum_q[0] + 25'(in_item_i.raw_x);
        raw_sum_q[1] <= raw_sum_q[1] + 25'(in_item_i.raw_y);
        raw_sum_q[2] <= raw_sum_q[2] + 25'(in_item_i.raw_z);
      end
      if (state_q == S_CAL_DIV && div_rsp.done) begin
        offset_q[axis_q] <= 32'(qsigned);
        est_q[axis_q]    <= 32'(qsigned);
        cov_q[axis_q]    <= ONE_Q24;
      end
      if (state_q == S_UPD_X) begin
        est_q[axis_q] <= x_sat;
      end
      if (state_q == S_UPD_P) begin
        cov_q[axis_q] <= 32'((cprod_q + 57'd8388608) >> 24);
      end
      if (state_q == S_POS_DIV && div_rsp.done) begin
        pos_q[axis_q] <= pos_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    meas_q  <= meas_d;
    p_q     <= p_d;
    k_q     <= k_d;
    prod_q  <= prod_d;
    cprod_q <= cprod_d;
    if (accept) begin
      raw_q[0] <= in_item_i.raw_x;
      raw_q[1] <= in_item_i.raw_y;
      raw_q[2] <= in_item_i.raw_z;
    end
    if (state_q == S_DONE && out_free) begin
      out_q.smooth_x   <= est_q[0];
      out_q.smooth_y   <= est_q[1];
      out_q.smooth_z   <= est_q[2];
      out_q.position_x <= pos_q[0];
      out_q.position_y <= pos_q[1];
      out_q.position_z <= pos_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
